/* design/dvc_pkg.sv */
// Package for the delta varint codec: queue entry and link types, fault and
// mode codes, field widths and the code length function.
// Depends on nothing; every other design file but dvc_ifs imports it.
package dvc_pkg;

   localparam int VALUE_BITS   = 64;
   localparam int DIFF_BITS    = 61;
   localparam int PAYLOAD_BITS = 5;
   localparam int TAG_SHIFT    = 5;
   localparam int MAX_LEN      = 8;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [1:0] FAULT_OK       = 2'd0;
   localparam logic [1:0] FAULT_DECREASE = 2'd1;
   localparam logic [1:0] FAULT_RANGE    = 2'd2;

   typedef struct packed {
      logic                  multi;
      logic [3:0]            len;
      logic [1:0]            fault;
      logic                  vvalid;
      logic [VALUE_BITS-1:0] data;
   } q_entry_type;

   typedef struct packed {
      logic        push;
      q_entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic        avail;
      q_entry_type entry;
   } q_head_type;

   function automatic logic [3:0] enc_length(input logic [VALUE_BITS-1:0] d);
      logic [3:0] n;
      n = 4'(MAX_LEN);
      for (int k = MAX_LEN - 1; k >= 1; k--) begin
         if ((d >> (8 * k - 3)) == '0) begin
            n = 4'(k);
         end
      end
      return n;
   endfunction

endpackage

/* design/dvc_ifs.sv */
// Request and response channel interfaces of the delta varint codec.
// Depends on nothing; used by the top level and its test environment.
interface dvc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [7:0]  code_byte;

   modport source (output valid, output value, output code_byte, input ready);
   modport sink   (input valid, input value, input code_byte, output ready);
endinterface

interface dvc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        out_last;
   logic [3:0]  code_length;
   logic [63:0] decoded_value;
   logic        value_valid;
   logic [1:0]  fault;

   modport source (output valid, output out_byte, output byte_valid, output out_last,
                   output code_length, output decoded_value, output value_valid,
                   output fault, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                   input code_length, input decoded_value, input value_valid,
                   input fault, output ready);
endinterface

/* design/dvc_front.sv */
// Front end: accepts requests, holds mode and the running state, computes
// difference, length and fault in encode mode and the running sum in decode.
// Depends on dvc_pkg.
module dvc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [63:0]        req_value,
   input  logic [7:0]         req_code_byte,
   input  logic               q_full,
   output dvc_pkg::q_push_type q_push
);
   import dvc_pkg::*;

   logic                  mode_ff;
   logic [VALUE_BITS-1:0] running_ff, running_in;
   logic [2:0]            left_ff, left_in;
   logic [DIFF_BITS-1:0]  partial_ff, partial_in;
   logic [3:0]            clen_ff, clen_in;

   logic                  accept;
   logic [VALUE_BITS-1:0] diff;
   logic                  below;
   logic                  too_big;
   logic                  done;
   q_entry_type           ent;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      diff       = req_value - running_ff;
      below      = req_value < running_ff;
      too_big    = diff[VALUE_BITS-1:DIFF_BITS] != '0;
      running_in = running_ff;
      left_in    = left_ff;
      partial_in = partial_ff;
      clen_in    = clen_ff;
      done       = 1'b0;
      ent        = '0;
      if (mode_ff == MODE_ENCODE) begin
         if (below) begin
            ent.fault = FAULT_DECREASE;
         end else if (too_big) begin
            ent.fault = FAULT_RANGE;
         end else begin
            ent.multi  = 1'b1;
            ent.len    = enc_length(diff);
            ent.data   = diff;
            running_in = req_value;
         end
      end else begin
         if (left_ff == 3'd0) begin
            clen_in    = 4'(req_code_byte[7:TAG_SHIFT]) + 4'd1;
            partial_in = DIFF_BITS'(req_code_byte[PAYLOAD_BITS-1:0]);
            left_in    = req_code_byte[7:TAG_SHIFT];
         end else begin
            partial_in = {partial_ff[DIFF_BITS-9:0], req_code_byte};
            left_in    = left_ff - 3'd1;
         end
         done = left_in == 3'd0;
         if (done) begin
            running_in = running_ff + VALUE_BITS'(partial_in);
         end
         ent.len    = clen_in;
         ent.vvalid = done;
         ent.data   = done ? running_in : '0;
      end
   end

   assign q_push.push  = accept;
   assign q_push.entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_ENCODE;
         running_ff <= '0;
         left_ff    <= '0;
         partial_ff <= '0;
         clen_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (accept) begin
            running_ff <= running_in;
            left_ff    <= left_in;
            partial_ff <= partial_in;
            clen_ff    <= clen_in;
         end
      end
   end

endmodule

/* design/dvc_queue.sv */
// Short FIFO of classified requests between front and back end.
// Depends on dvc_pkg.
module dvc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  dvc_pkg::q_push_type q_push,
   output logic                q_full,
   output dvc_pkg::q_head_type q_head,
   input  logic                q_pop
);
   import dvc_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   q_entry_type   ents_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] cnt_ff;
   logic          do_push, do_pop;

   assign q_full       = cnt_ff == CW'(DEPTH);
   assign q_head.avail = cnt_ff != '0;
   assign q_head.entry = ents_ff[rd_ptr_ff];
   assign do_push      = q_push.push && !q_full;
   assign do_pop       = q_pop && q_head.avail;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         ents_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

endmodule

/* design/dvc_back.sv */
// Back end: expands queued encode entries into code bytes, passes single
// results through, and holds the response output register.
// Depends on dvc_pkg.
module dvc_back (
   input  logic                clock,
   input  logic                reset,
   input  dvc_pkg::q_head_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_out_last,
   output logic [3:0]          rsp_code_length,
   output logic [63:0]         rsp_decoded_value,
   output logic                rsp_value_valid,
   output logic [1:0]          rsp_fault
);
   import dvc_pkg::*;

   logic        valid_ff;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  byte_ff, byte_in;
   logic        bvalid_ff;
   logic        last_ff, last_in;
   logic [3:0]  len_ff;
   logic [63:0] dval_ff;
   logic        vvalid_ff;
   logic [1:0]  fault_ff;

   logic        advance;
   logic        load;
   logic [2:0]  pos;
   q_entry_type ent;

   assign ent     = q_head.entry;
   assign advance = !valid_ff || rsp_ready;
   assign load    = advance && q_head.avail;

   always_comb begin
      pos     = 3'(ent.len - 4'd1) - idx_ff;
      byte_in = 8'(ent.data >> {pos, 3'b000});
      if (idx_ff == 3'd0) begin
         byte_in = {3'(ent.len - 4'd1), byte_in[PAYLOAD_BITS-1:0]};
      end
      last_in = !ent.multi || (pos == 3'd0);
      idx_in  = last_in ? 3'd0 : idx_ff + 3'd1;
   end

   assign q_pop = load && last_in;

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= ent.multi ? byte_in : 8'd0;
         bvalid_ff <= ent.multi;
         last_ff   <= last_in;
         len_ff    <= ent.len;
         dval_ff   <= ent.multi ? 64'd0 : ent.data;
         vvalid_ff <= ent.vvalid;
         fault_ff  <= ent.fault;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (advance) begin
            valid_ff <= q_head.avail;
         end
         if (load) begin
            idx_ff <= idx_in;
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_byte_valid    = bvalid_ff;
   assign rsp_out_last      = last_ff;
   assign rsp_code_length   = len_ff;
   assign rsp_decoded_value = dval_ff;
   assign rsp_value_valid   = vvalid_ff;
   assign rsp_fault         = fault_ff;

endmodule

/* design/delta_varint_codec.sv */
// Channel   Dir  Handshake          Payload
// req       in   valid/ready        value[63:0], code_byte[7:0]
// rsp       out  valid/ready        out_byte, byte_valid, out_last, code_length,
//                                   decoded_value, value_valid, fault
// csr       in   csr_wr_en          csr_wr_data (mode)
//
// A request is taken each cycle the queue has room; the queue registers it and, with the back
// end free, its first result then loads the output register, from which the response is taken.
// Decode and fault requests give one result a cycle while the response is not stalled; an
// encoded value holds the back end until all its code bytes have drained, one per result.
// Reset is synchronous and clears mode, running state, queue and output valid.
// A stalled response holds the back end; requests continue until the queue fills.
// Top level of the delta varint codec; depends on dvc_pkg, dvc_ifs, dvc_front,
// dvc_queue and dvc_back.
module delta_varint_codec #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   dvc_req_if.sink   req,
   dvc_rsp_if.source rsp
);
   import dvc_pkg::*;

   q_push_type q_push;
   q_head_type q_head;
   logic       q_full;
   logic       q_pop;

   dvc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req.valid),
      .req_ready     (req.ready),
      .req_value     (req.value),
      .req_code_byte (req.code_byte),
      .q_full        (q_full),
      .q_push        (q_push)
   );

   dvc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   dvc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_out_byte      (rsp.out_byte),
      .rsp_byte_valid    (rsp.byte_valid),
      .rsp_out_last      (rsp.out_last),
      .rsp_code_length   (rsp.code_length),
      .rsp_decoded_value (rsp.decoded_value),
      .rsp_value_valid   (rsp.value_valid),
      .rsp_fault         (rsp.fault)
   );

endmodule

/* dv/dvc_checker.sv */
`timescale 1ns / 1ps
// Checker for the delta varint codec: watches the request, response and csr ports,
// predicts every response and compares it with what the codec returns.
// Depends on dvc_pkg and the dvc_req_if / dvc_rsp_if interfaces.
module dvc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   dvc_req_if          req,
   dvc_rsp_if          rsp,
   output int          fail_count,
   output int          due_count,
   output logic [63:0] sum_value
);
   import dvc_pkg::*;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        out_last;
      logic [3:0]  code_length;
      logic [63:0] decoded_value;
      logic        value_valid;
      logic [1:0]  fault;
   } rsp_item_type;

   rsp_item_type         due_results[$];
   logic                 mode;
   logic [2:0]           bytes_due;
   logic [DIFF_BITS-1:0] diff_acc;
   logic [3:0]           cur_len;
   int                   report_count;

   initial begin
      fail_count   = 0;
      due_count    = 0;
      report_count = 0;
      sum_value    = '0;
      mode         = MODE_ENCODE;
      bytes_due    = '0;
      diff_acc     = '0;
      cur_len      = '0;
   end

   task automatic encode_value(input logic [63:0] v);
      logic [63:0]  diff;
      int           len;
      rsp_item_type r;
      diff = v - sum_value;
      r = '0;
      r.out_last = 1'b1;
      if (v < sum_value) begin
         r.fault = FAULT_DECREASE;
         due_results.insert(due_results.size(), r);
      end else if ((diff >> DIFF_BITS) != 0) begin
         r.fault = FAULT_RANGE;
         due_results.insert(due_results.size(), r);
      end else begin
         len = 1;
         while (len < MAX_LEN && (diff >> (8 * len - 3)) != 0) len++;
         for (int k = 0; k < len; k++) begin
            r = '0;
            r.out_byte = 8'(diff >> (8 * (len - 1 - k)));
            if (k == 0) begin
               r.out_byte = {3'(len - 1), r.out_byte[PAYLOAD_BITS-1:0]};
            end
            r.byte_valid  = 1'b1;
            r.out_last    = (k == len - 1);
            r.code_length = 4'(len);
            due_results.insert(due_results.size(), r);
         end
         sum_value = v;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b);
      rsp_item_type r;
      if (bytes_due == 0) begin
         cur_len   = {1'b0, b[7:5]} + 4'd1;
         diff_acc  = '0;
         diff_acc[PAYLOAD_BITS-1:0] = b[PAYLOAD_BITS-1:0];
         bytes_due = b[7:5];
      end else begin
         diff_acc  = {diff_acc[DIFF_BITS-9:0], b};
         bytes_due = bytes_due - 3'd1;
      end
      r = '0;
      r.out_last    = 1'b1;
      r.code_length = cur_len;
      if (bytes_due == 0) begin
         sum_value       = sum_value + 64'(diff_acc);
         r.decoded_value = sum_value;
         r.value_valid   = 1'b1;
      end
      due_results.insert(due_results.size(), r);
   endtask

   always @(posedge clock) begin : watch
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         due_results.delete();
         mode      = MODE_ENCODE;
         sum_value = '0;
         bytes_due = '0;
         diff_acc  = '0;
         cur_len   = '0;
      end else begin
         if (req.valid && req.ready) begin
            if (mode == MODE_ENCODE) encode_value(req.value);
            else decode_byte(req.code_byte);
         end
         if (csr_wr_en) mode = csr_wr_data;
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.out_byte, rsp.byte_valid, rsp.out_last, rsp.code_length,
                    rsp.decoded_value, rsp.value_valid, rsp.fault};
            if (due_results.size() == 0) begin
               fail_count++;
               if (report_count < 10) begin
                  report_count++;
                  $display("unexpected response at %0t: byte %h len %0d value %h fault %0d",
                           $realtime, got.out_byte, got.code_length, got.decoded_value,
                           got.fault);
               end
            end else begin
               want = due_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (report_count < 10) begin
                     report_count++;
                     $display("mismatch at %0t", $realtime);
                     $display("  want byte %h bv %b last %b len %0d value %h vv %b fault %0d",
                              want.out_byte, want.byte_valid, want.out_last,
                              want.code_length, want.decoded_value, want.value_valid,
                              want.fault);
                     $display("  got  byte %h bv %b last %b len %0d value %h vv %b fault %0d",
                              got.out_byte, got.byte_valid, got.out_last, got.code_length,
                              got.decoded_value, got.value_valid, got.fault);
                  end
               end
            end
         end
      end
      due_count = due_results.size();
   end

endmodule

/* dv/tb_delta_varint_codec.sv */
`timescale 1ns / 1ps
// Testbench top for the delta varint codec: clock, reset, request stimulus,
// response back-pressure, mode writes and the final verdict.
// Depends on dvc_pkg, the channel interfaces, delta_varint_codec and dvc_checker.
module tb_delta_varint_codec;
   import dvc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   int          fail_count;
   int          due_count;
   logic [63:0] sum_value;
   int          req_idle_pct;
   int          rsp_stall_pct;
   int          sent_count;
   int          cycle_count = 0;

   dvc_req_if req ();
   dvc_rsp_if rsp ();

   delta_varint_codec DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req),
      .rsp         (rsp)
   );

   dvc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req),
      .rsp         (rsp),
      .fail_count  (fail_count),
      .due_count   (due_count),
      .sum_value   (sum_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_request(input logic [63:0] v, input logic [7:0] b);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid     = 1'b1;
      req.value     = v;
      req.code_byte = b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic set_mode(input logic m);
      req.valid = 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = m;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic encode_random();
      logic [63:0] d;
      int          cls;
      int          pick;
      pick = $urandom_range(0, 99);
      cls  = ($urandom_range(0, 15) == 0) ? MAX_LEN : $urandom_range(1, MAX_LEN - 1);
      d    = rand64() & ((64'd1 << (8 * cls - 3)) - 64'd1);
      if (pick < 8) begin
         send_request(sum_value - 64'($urandom_range(1, 1000)), 8'($urandom));
      end else if (pick < 14) begin
         send_request(sum_value + (64'd1 << DIFF_BITS) + 64'($urandom_range(0, 255)),
                      8'($urandom));
      end else begin
         if (d > ~sum_value) d = ~sum_value;
         send_request(sum_value + d, 8'($urandom));
      end
   endtask

   task automatic decode_random();
      int len;
      if ($urandom_range(0, 99) < 15) begin
         send_request(rand64(), 8'($urandom));
      end else begin
         len = ($urandom_range(0, 15) == 0) ? MAX_LEN : $urandom_range(1, 4);
         send_request(rand64(), {3'(len - 1), 5'($urandom)});
         for (int k = 1; k < len; k++) send_request(rand64(), 8'($urandom));
      end
   endtask

   initial begin : stimulus
      int stop_count;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 1'b0;
      req.valid     = 1'b0;
      req.value     = '0;
      req.code_byte = '0;
      rsp.ready     = 1'b0;
      sent_count    = 0;
      req_idle_pct  = 37;
      rsp_stall_pct = 75;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      set_mode(MODE_ENCODE);
      send_request(64'd0, 8'($urandom));
      send_request(64'd31, 8'($urandom));
      for (int n = 1; n < MAX_LEN; n++) begin
         send_request(sum_value + (64'd1 << (8 * n - 3)), 8'($urandom));
      end
      send_request(sum_value + (64'd1 << DIFF_BITS) - 64'd1, 8'($urandom));
      send_request(sum_value + (64'd1 << DIFF_BITS), 8'($urandom));
      send_request(sum_value - 64'd1, 8'($urandom));
      send_request('1, 8'($urandom));

      // split a decode code around an encode
      set_mode(MODE_DECODE);
      send_request(rand64(), {3'd2, 5'($urandom)});
      set_mode(MODE_ENCODE);
      send_request(sum_value + 64'd5, 8'($urandom));
      set_mode(MODE_DECODE);
      repeat (2) send_request(rand64(), 8'($urandom));
      repeat (MAX_LEN) send_request(rand64(), 8'hFF);

      for (int prof = 0; prof < 3; prof++) begin
         case (prof)
            0: begin
               req_idle_pct  = 37;
               rsp_stall_pct = 75;
            end
            1: begin
               req_idle_pct  = 75;
               rsp_stall_pct = 37;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            set_mode((seg % 2 == 0) ? MODE_ENCODE : MODE_DECODE);
            stop_count = sent_count + 12;
            while (sent_count < stop_count) begin
               if (seg % 2 == 0) encode_random();
               else decode_random();
            end
         end
      end

      req.valid = 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* delta_varint_codec.f */
design/dvc_pkg.sv
design/dvc_ifs.sv
design/dvc_front.sv
design/dvc_queue.sv
design/dvc_back.sv
design/delta_varint_codec.sv
dv/dvc_checker.sv
dv/tb_delta_varint_codec.sv
